// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property violated");
// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/rtyp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtyp_pkg
// Shared types and constants of the RGB to YUYV packer.
// ----------------------------------------------------------------------------
package rtyp_pkg;

  // Frame size limits and field widths
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int CfgW      = 13;
  localparam int CfgIdxW   = 1;
  localparam int PixW      = 8;

  // Configuration register indexes and reset values
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;
  localparam logic [CfgW-1:0]    WidthReset     = 13'd640;
  localparam logic [CfgW-1:0]    HeightReset    = 13'd480;

  // What the back end does with a pixel
  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_PAIR,
    KIND_TAIL
  } pix_kind_e;

  // Classified pixel passed from front to back
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    pix_kind_e       kind;
    logic            row_end;
    logic            frame_end;
  } pix_item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/rtyp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtyp_front
// Holds the size registers and the column and row counters, and tags each
// accepted pixel as held, pair end or lone tail with its row and frame flags.
// ----------------------------------------------------------------------------
module rtyp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtyp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtyp_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          take_i,
  input  logic [rtyp_pkg::PixW-1:0]     red_i,
  input  logic [rtyp_pkg::PixW-1:0]     green_i,
  input  logic [rtyp_pkg::PixW-1:0]     blue_i,
  output rtyp_pkg::pix_item_t           item_o
);

  logic [rtyp_pkg::CfgW-1:0] fw_q, fh_q;
  logic [rtyp_pkg::ColW-1:0] col_q, col_d;
  logic [rtyp_pkg::RowW-1:0] row_q, row_d;
  logic [rtyp_pkg::ColW:0]   w_eff;
  logic [rtyp_pkg::RowW:0]   h_eff;
  logic                      last_col, last_row, odd_col;

  // Clamp the size registers to 1..max
  always_comb begin
    if (fw_q == '0) begin
      w_eff = (rtyp_pkg::ColW+1)'(1);
    end else if (32'(fw_q) > 32'(rtyp_pkg::MaxWidth)) begin
      w_eff = (rtyp_pkg::ColW+1)'(rtyp_pkg::MaxWidth);
    end else begin
      w_eff = (rtyp_pkg::ColW+1)'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = (rtyp_pkg::RowW+1)'(1);
    end else if (32'(fh_q) > 32'(rtyp_pkg::MaxHeight)) begin
      h_eff = (rtyp_pkg::RowW+1)'(rtyp_pkg::MaxHeight);
    end else begin
      h_eff = (rtyp_pkg::RowW+1)'(fh_q);
    end
  end

  // Classify the pixel from the counters
  assign last_col = ({1'b0, col_q} + 1'b1) >= w_eff;
  assign last_row = ({1'b0, row_q} + 1'b1) >= h_eff;
  assign odd_col  = col_q[0];

  always_comb begin
    item_o.red       = red_i;
    item_o.green     = green_i;
    item_o.blue      = blue_i;
    item_o.row_end   = last_col;
    item_o.frame_end = last_col && last_row;
    if (odd_col) begin
      item_o.kind = rtyp_pkg::KIND_PAIR;
    end else if (last_col) begin
      item_o.kind = rtyp_pkg::KIND_TAIL;
    end else begin
      item_o.kind = rtyp_pkg::KIND_HOLD;
    end
  end

  // Advance the counters, wrap at row and frame end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= rtyp_pkg::WidthReset;
      fh_q  <= rtyp_pkg::HeightReset;
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i && cfg_idx_i == rtyp_pkg::RegFrameWidth) begin
        fw_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == rtyp_pkg::RegFrameHeight) begin
        fh_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== sv/rtyp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtyp_queue
// Two-entry queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
module rtyp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtyp_pkg::pix_item_t item_i,
  input  logic                pop_i,
  output rtyp_pkg::pix_item_t item_o,
  output rtyp_pkg::q_stat_t   stat_o
);

  rtyp_pkg::pix_item_t slot_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q, count_d;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/rtyp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtyp_back
// Converts RGB to Y, U, V in one stage, then packs pairs or lone tails into
// YUYV words in the output register.
// ----------------------------------------------------------------------------
module rtyp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rtyp_pkg::pix_item_t           item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rtyp_pkg::PixW-1:0]     luma_first_o,
  output logic [rtyp_pkg::PixW-1:0]     chroma_u_o,
  output logic [rtyp_pkg::PixW-1:0]     luma_second_o,
  output logic [rtyp_pkg::PixW-1:0]     chroma_v_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);

  // Take bits 15:8 of a weighted sum, limited to 0..255
  function automatic logic [7:0] clamp_sum(input logic signed [17:0] s);
    if (s < 0) begin
      return 8'd0;
    end else if (s[17:16] != 2'b00) begin
      return 8'hFF;
    end else begin
      return s[15:8];
    end
  endfunction

  logic signed [17:0] re, ge, be;
  logic signed [17:0] ys, us, vs;

  logic                a_valid_q;
  logic [7:0]          a_y_q, a_u_q, a_v_q;
  rtyp_pkg::pix_kind_e a_kind_q;
  logic                a_row_end_q, a_frame_end_q;

  logic [7:0] held_y_q, held_u_q, held_v_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] lf_d, cu_d, ls_d, cv_d;
  logic [8:0] u_sum, v_sum;
  logic       ready_b, ready_a;

  // Stage handshake
  assign ready_b = !out_valid_q || !out_stall_i;
  assign ready_a = !a_valid_q || ready_b;
  assign pop_o   = valid_i && ready_a;

  // Weighted sums of the color components
  assign re = $signed({10'd0, item_i.red});
  assign ge = $signed({10'd0, item_i.green});
  assign be = $signed({10'd0, item_i.blue});
  assign ys = 18'sd77 * re + 18'sd150 * ge + 18'sd29 * be;
  assign us = 18'sd32768 + 18'sd128 * be - 18'sd43 * re - 18'sd85 * ge;
  assign vs = 18'sd32768 + 18'sd128 * re - 18'sd107 * ge - 18'sd21 * be;

  // Register converted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_a) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_y_q         <= clamp_sum(ys);
      a_u_q         <= clamp_sum(us);
      a_v_q         <= clamp_sum(vs);
      a_kind_q      <= item_i.kind;
      a_row_end_q   <= item_i.row_end;
      a_frame_end_q <= item_i.frame_end;
    end
  end

  // Pack the output word
  assign u_sum = {1'b0, held_u_q} + {1'b0, a_u_q};
  assign v_sum = {1'b0, held_v_q} + {1'b0, a_v_q};

  always_comb begin
    out_valid_d = 1'b0;
    lf_d        = a_y_q;
    cu_d        = a_u_q;
    ls_d        = a_y_q;
    cv_d        = a_v_q;
    case (a_kind_q)
      rtyp_pkg::KIND_PAIR: begin
        out_valid_d = a_valid_q;
        lf_d        = held_y_q;
        cu_d        = u_sum[8:1];
        cv_d        = v_sum[8:1];
      end
      rtyp_pkg::KIND_TAIL: begin
        out_valid_d = a_valid_q;
      end
      rtyp_pkg::KIND_HOLD: begin
        out_valid_d = 1'b0;
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_y_q    <= '0;
      held_u_q    <= '0;
      held_v_q    <= '0;
    end else if (ready_b) begin
      out_valid_q <= out_valid_d;
      if (a_valid_q && a_kind_q == rtyp_pkg::KIND_HOLD) begin
        held_y_q <= a_y_q;
        held_u_q <= a_u_q;
        held_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && out_valid_d) begin
      luma_first_o  <= lf_d;
      chroma_u_o    <= cu_d;
      luma_second_o <= ls_d;
      chroma_v_o    <= cv_d;
      row_end_o     <= a_row_end_q;
      frame_end_o   <= a_frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/rgb_to_yuyv_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuyv_packer
// RGB888 pixels in raster order in, YUYV 4:2:2 words out.
//
// Input channel: one pixel (red_i, green_i, blue_i) per transaction, taken
// when in_valid_i is high and in_stall_o is low. Output channel: one YUYV
// word per pixel pair, or per lone last pixel of an odd-width row, with
// row_end_o and frame_end_o, taken when out_valid_o is high and out_stall_i
// is low. Sizes are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user writes them only while the block is idle, which the block does not
// enforce; counters are kept across such writes. The block takes one pixel
// per clock unless the receiver stalls: the front end classifies, a
// two-entry queue decouples it from a two-stage back end (convert, then
// pack). When the receiver stalls, the output register holds its word, the
// back end fills, then the queue fills and in_stall_o rises. Reset clears
// counters, held pixel and queue; sizes return to 640 x 480.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_yuyv_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtyp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtyp_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rtyp_pkg::PixW-1:0]     red_i,
  input  logic [rtyp_pkg::PixW-1:0]     green_i,
  input  logic [rtyp_pkg::PixW-1:0]     blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rtyp_pkg::PixW-1:0]     luma_first_o,
  output logic [rtyp_pkg::PixW-1:0]     chroma_u_o,
  output logic [rtyp_pkg::PixW-1:0]     luma_second_o,
  output logic [rtyp_pkg::PixW-1:0]     chroma_v_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);

  rtyp_pkg::pix_item_t front_item, q_item;
  rtyp_pkg::q_stat_t   q_stat;
  logic                take, pop;

  // Accept while the queue has room
  assign in_stall_o = q_stat.full;
  assign take       = in_valid_i && !q_stat.full;

  rtyp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .item_o      (front_item)
  );

  rtyp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  rtyp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_stat.empty),
    .item_i        (q_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .luma_first_o  (luma_first_o),
    .chroma_u_o    (chroma_u_o),
    .luma_second_o (luma_second_o),
    .chroma_v_o    (chroma_v_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  // Frame end is a row end; queue never full and empty, never popped empty
  `ASSERT_PROP(a_frame_in_row, clk_i, rst_ni, out_valid_o |-> (!frame_end_o || row_end_o))
  `ASSERT_NEVER(a_queue_stat, clk_i, rst_ni, q_stat.full && q_stat.empty)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_stat.empty)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the RGB to YUYV 4:2:2 packer.
//
// Drives pixels in raster order through the valid/stall input and collects
// YUYV words on the valid/stall output. A scoreboard converts every accepted
// pixel, pairs it with the held one, tracks the column and row counters and
// the size registers, and compares each word field by field.
// Directed frames cover black/white and primary colors, zero and oversized
// sizes, and counters left past the row or frame end by a size change. Then
// random frames run under three idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import rtyp_pkg::*;

  localparam int Items         = 400;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 10;
  localparam int HoldOffCycles = 40;

  // One YUYV word with its row and frame flags
  typedef struct packed {
    logic [PixW-1:0] luma_first;
    logic [PixW-1:0] chroma_u;
    logic [PixW-1:0] luma_second;
    logic [PixW-1:0] chroma_v;
    logic            row_end;
    logic            frame_end;
  } yuyv_word_t;

  // Pixel-to-word predictor and the queue of words still to arrive
  class yuyv_scoreboard;
    yuyv_word_t      expected_words[$];
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    int unsigned     col_count;
    int unsigned     row_count;
    logic [PixW-1:0] held_y;
    logic [PixW-1:0] held_u;
    logic [PixW-1:0] held_v;
    int              errors;

    function new();
      width_reg  = WidthReset;
      height_reg = HeightReset;
      col_count  = 0;
      row_count  = 0;
      held_y     = '0;
      held_u     = '0;
      held_v     = '0;
      errors     = 0;
    endfunction

    function void write_size(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      if (idx == RegFrameWidth) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    // Zero counts as one, oversized saturates
    function int unsigned effective(logic [CfgW-1:0] value, int unsigned max_size);
      if (value == 0) return 1;
      if (value > max_size) return max_size;
      return value;
    endfunction

    function logic [PixW-1:0] to_byte(int value);
      if (value < 0) return 8'd0;
      if (value > 255) return 8'd255;
      return value[PixW-1:0];
    endfunction

    // Convert one accepted pixel; hold it or queue the word it completes
    function void note_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g,
                             logic [PixW-1:0] b);
      int unsigned  w;
      int unsigned  h;
      int           ri;
      int           gi;
      int           bi;
      logic [PixW-1:0] y;
      logic [PixW-1:0] u;
      logic [PixW-1:0] v;
      logic [PixW:0]   sum_u;
      logic [PixW:0]   sum_v;
      logic         last_col;
      logic         odd_col;
      logic         last_row;
      yuyv_word_t   word;
      w  = effective(width_reg, MaxWidth);
      h  = effective(height_reg, MaxHeight);
      ri = r;
      gi = g;
      bi = b;
      y  = to_byte((77 * ri + 150 * gi + 29 * bi) / 256);
      u  = to_byte((32768 + 128 * bi - 43 * ri - 85 * gi) / 256);
      v  = to_byte((32768 + 128 * ri - 107 * gi - 21 * bi) / 256);
      last_col = (col_count + 1 >= w);
      odd_col  = col_count[0];

      // Hold the first pixel of a pair
      if (!odd_col && !last_col) begin
        held_y    = y;
        held_u    = u;
        held_v    = v;
        col_count = col_count + 1;
        return;
      end

      if (odd_col) begin
        sum_u = {1'b0, held_u} + {1'b0, u};
        sum_v = {1'b0, held_v} + {1'b0, v};
        word.luma_first  = held_y;
        word.chroma_u    = sum_u[PixW:1];
        word.luma_second = y;
        word.chroma_v    = sum_v[PixW:1];
      end else begin
        // Lone tail pixel repeats its own luma
        word.luma_first  = y;
        word.chroma_u    = u;
        word.luma_second = y;
        word.chroma_v    = v;
      end

      if (last_col) begin
        last_row       = (row_count + 1 >= h);
        word.row_end   = 1'b1;
        word.frame_end = last_row;
        col_count      = 0;
        row_count      = last_row ? 0 : row_count + 1;
      end else begin
        word.row_end   = 1'b0;
        word.frame_end = 1'b0;
        col_count      = col_count + 1;
      end
      expected_words.push_back(word);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Match one received word against the oldest expectation
    function void check_word(yuyv_word_t got);
      yuyv_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: word with nothing pending: expected none, actual %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare("luma_first", want.luma_first, got.luma_first);
      compare("chroma_u", want.chroma_u, got.chroma_u);
      compare("luma_second", want.luma_second, got.luma_second);
      compare("chroma_v", want.chroma_v, got.chroma_v);
      compare("row_end", want.row_end, got.row_end);
      compare("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     red_i;
  logic [PixW-1:0]     green_i;
  logic [PixW-1:0]     blue_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     luma_first_o;
  logic [PixW-1:0]     chroma_u_o;
  logic [PixW-1:0]     luma_second_o;
  logic [PixW-1:0]     chroma_v_o;
  logic                row_end_o;
  logic                frame_end_o;

  yuyv_scoreboard board = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  bit             pressure_armed = 1'b0;
  bit             pressure_done  = 1'b0;
  int unsigned    hold_left      = 0;
  int unsigned    cycle_count    = 0;

  // Black, white, primaries and secondaries
  logic [23:0] corner_colors [8] = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                                     24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff};

  rgb_to_yuyv_packer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .luma_first_o (luma_first_o),
    .chroma_u_o   (chroma_u_o),
    .luma_second_o(luma_second_o),
    .chroma_v_o   (chroma_v_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check each output transaction and choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_word('{luma_first_o, chroma_u_o, luma_second_o, chroma_v_o,
                         row_end_o, frame_end_o});
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (pressure_armed && !pressure_done) begin
      // Long hold-off so the block backs up into its input
      out_stall_i  <= 1'b1;
      hold_left     = HoldOffCycles;
      pressure_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [PixW-1:0] pick_channel();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255));
  endfunction

  // Offer one pixel, idling first at random; valid stays high on return
  task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_pixel(r, g, b);
  endtask

  // Drop valid and wait until every pending word is out and the pipe is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_sizes(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegFrameWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    board.write_size(RegFrameWidth, w);
    cfg_idx_i   <= RegFrameHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    board.write_size(RegFrameHeight, h);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int              sent;
    int              count;
    int unsigned     sel;
    logic [CfgW-1:0] w;
    logic [CfgW-1:0] h;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegFrameWidth;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme colors at the reset size
    foreach (corner_colors[i]) begin
      send_pixel(corner_colors[i][23:16], corner_colors[i][15:8], corner_colors[i][7:0]);
    end

    // Zero sizes act as 1 x 1: every pixel is a lone tail ending the frame
    drain();
    write_sizes(13'd0, 13'd0);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);

    // Odd width: pairs plus a tail on each row
    drain();
    write_sizes(13'd3, 13'd2);
    repeat (6) send_pixel(pick_channel(), pick_channel(), pick_channel());

    // Oversized sizes saturate; then shrink the width under an odd column
    drain();
    write_sizes(13'd8191, 13'd8191);
    repeat (3) send_pixel(pick_channel(), pick_channel(), pick_channel());
    drain();
    write_sizes(13'd2, 13'd8191);
    send_pixel(pick_channel(), pick_channel(), pick_channel());

    // Shrink the height under the current row count
    drain();
    write_sizes(13'd1, 13'd1);
    send_pixel(pick_channel(), pick_channel(), pick_channel());

    // Random frames under three idle patterns
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct  = (regime == 0) ? 13 : (regime == 1) ? 70 : 0;
      recv_stall_pct = (regime == 0) ? 70 : (regime == 1) ? 13 : 0;
      sent = 0;
      while (sent < Items / 3) begin
        drain();
        sel = $urandom_range(19);
        if (regime == 2 && sent == 0) begin
          w     = 13'd64;
          h     = 13'd4;
          count = 80;
        end else if (sel == 0) begin
          w     = $urandom_range(1) ? 13'd4096 : 13'($urandom_range(8191, 4097));
          h     = 13'($urandom_range(8191));
          count = $urandom_range(6, 1);
        end else if (sel == 1) begin
          w     = 13'd0;
          h     = 13'($urandom_range(2));
          count = $urandom_range(4, 1);
        end else begin
          w     = 13'($urandom_range(9, 1));
          h     = 13'($urandom_range(4, 1));
          count = int'(w) * int'(h) * $urandom_range(2, 1) + $urandom_range(3);
        end
        write_sizes(w, h);
        if (regime == 2 && sent == 0) pressure_armed = 1'b1;
        repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
        sent += count;
      end
    end

    drain();
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rtyp_pkg.sv
sv/rtyp_front.sv
sv/rtyp_queue.sv
sv/rtyp_back.sv
sv/rgb_to_yuyv_packer.sv
dv/tb.sv
